FILE: src/swm_pkg.sv
// shared constants for the sliding window maximum block
`timescale 1ns / 1ps

package swm_pkg;

   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int WINDOW_MAX_DEF   = 256;
   localparam int LEN_W            = 9;

endpackage

FILE: src/swm_if.sv
// channel interfaces for sample, result and window length words
`timescale 1ns / 1ps

interface swm_req_if #(parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface swm_rsp_if #(parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] window_max;

   modport source (output valid, output window_max, input ready);
   modport sink   (input valid, input window_max, output ready);
endinterface

interface swm_csr_if;
   import swm_pkg::*;
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] window_length;

   modport source (output valid, output window_length, input ready);
   modport sink   (input valid, input window_length, output ready);
endinterface

FILE: src/sliding_window_max_top.sv
// sliding window maximum top level: two-stack queue held in two rams
//
// req_chan carries sample words, rsp_chan carries window_max words and
// csr_chan writes window_length (0 acts as 1, above WINDOW_MAX acts as
// WINDOW_MAX). A window_length write empties the window; no result comes
// until window_length samples have been taken, then one result per sample.
// A sample that only fills the window gives no result. A sample that needs
// no refill is pushed onto the back stack in the cycle it is accepted in,
// which also reads the front stack; in ST_EMIT the result register is then
// loaded once it is empty or rsp_chan is ready. Once every window_length
// samples the front stack is empty and the back stack is moved onto it
// through the back ram read port, one entry a cycle, before that sample is
// pushed in ST_PUSH. A new sample is taken only in ST_IDLE, so not before
// the last one has been pushed and, once the window is full, its result loaded.
// The result register lets the next sample be accepted while a result is
// still held; if rsp_chan stalls, the following result waits in place and
// no further sample is taken. Reset empties the window and sets
// window_length to 1; csr_chan is always ready and must be written idle.
`timescale 1ns / 1ps

module sliding_window_max_top #(
   parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
   input logic    clock,
   input logic    reset,
   swm_req_if.sink  req_chan,
   swm_rsp_if.source rsp_chan,
   swm_csr_if.sink  csr_chan
);

   import swm_pkg::*;

   localparam int AW = $clog2(WINDOW_MAX);
   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int EW = (CW > LEN_W) ? CW : LEN_W;
   localparam logic [SAMPLE_WIDTH-1:0] SIGN_BIT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic [SAMPLE_WIDTH-1:0] KEY_MIN  = '0;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MOVE = 4'b0010,
      ST_PUSH = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [CW-1:0]            fill_count_ff, fill_count_in;
   logic [CW-1:0]            back_count_ff, back_count_in;
   logic [CW-1:0]            front_count_ff, front_count_in;
   logic [SAMPLE_WIDTH-1:0]  brm_ff, brm_in;
   logic [SAMPLE_WIDTH-1:0]  fpm_ff, fpm_in;
   logic [SAMPLE_WIDTH-1:0]  key_ff, key_in;
   logic                     mv_pend_ff, mv_pend_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]  rsp_data_ff, rsp_data_in;

   logic [EW-1:0]            len_ext, wmax_ext, eff_len, fill_ext;
   logic                     steady, need_move, req_fire, do_push;
   logic [SAMPLE_WIDTH-1:0]  push_key, move_pm, front_top, result_key;
   logic [CW-1:0]            back_dec, front_dec2;

   logic                     back_we, back_re, front_we, front_re;
   logic [AW-1:0]            back_waddr, back_raddr, front_waddr, front_raddr;
   logic [SAMPLE_WIDTH-1:0]  back_wdata, front_wdata, back_q, front_q;

   swm_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(WINDOW_MAX)) u_back_ram (
      .clock   (clock),
      .wr_en   (back_we),
      .wr_addr (back_waddr),
      .wr_data (back_wdata),
      .rd_en   (back_re),
      .rd_addr (back_raddr),
      .rd_data (back_q)
   );

   swm_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(WINDOW_MAX)) u_front_ram (
      .clock   (clock),
      .wr_en   (front_we),
      .wr_addr (front_waddr),
      .wr_data (front_wdata),
      .rd_en   (front_re),
      .rd_addr (front_raddr),
      .rd_data (front_q)
   );

   // effective window length
   assign len_ext  = EW'(len_ff);
   assign wmax_ext = EW'(WINDOW_MAX);
   assign eff_len  = (len_ff == '0) ? EW'(1) : ((len_ext > wmax_ext) ? wmax_ext : len_ext);
   assign fill_ext = EW'(fill_count_ff);

   assign steady     = (fill_ext >= eff_len);
   assign need_move  = steady && (front_count_ff == '0);
   assign req_fire   = req_chan.valid && req_chan.ready;
   assign do_push    = (state_ff == ST_PUSH) || (req_fire && !need_move);
   assign push_key   = (state_ff == ST_PUSH) ? key_ff
                                             : (SAMPLE_WIDTH'(req_chan.sample) ^ SIGN_BIT);
   assign back_dec   = back_count_ff - CW'(1);
   assign front_dec2 = front_count_ff - CW'(2);
   assign move_pm    = (back_q > fpm_ff) ? back_q : fpm_ff;
   assign front_top  = (front_count_ff != '0) ? front_q : KEY_MIN;
   assign result_key = (brm_ff > front_top) ? brm_ff : front_top;

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.window_max = rsp_data_ff;
   assign csr_chan.ready      = 1'b1;

   always_comb begin
      state_in       = state_ff;
      len_in         = len_ff;
      fill_count_in  = fill_count_ff;
      back_count_in  = back_count_ff;
      front_count_in = front_count_ff;
      brm_in         = brm_ff;
      fpm_in         = fpm_ff;
      key_in         = key_ff;
      mv_pend_in     = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in    = rsp_data_ff;

      back_we     = 1'b0;
      back_waddr  = back_count_ff[AW-1:0];
      back_wdata  = push_key;
      back_re     = 1'b0;
      back_raddr  = back_dec[AW-1:0];
      front_we    = 1'b0;
      front_waddr = front_count_ff[AW-1:0];
      front_wdata = move_pm;
      front_re    = 1'b0;
      front_raddr = front_dec2[AW-1:0];

      if (req_fire) begin
         key_in = SAMPLE_WIDTH'(req_chan.sample) ^ SIGN_BIT;
         if (need_move) begin
            fpm_in   = KEY_MIN;
            state_in = ST_MOVE;
         end
      end

      // push onto back stack, pop front stack once the window is full
      if (do_push) begin
         back_we       = 1'b1;
         back_count_in = back_count_ff + CW'(1);
         brm_in        = (push_key > brm_ff) ? push_key : brm_ff;
         if (steady) begin
            front_count_in = front_count_ff - CW'(1);
            front_re       = (front_count_ff > CW'(1));
            state_in       = ST_EMIT;
         end else begin
            fill_count_in = fill_count_ff + CW'(1);
            state_in      = ((fill_ext + EW'(1)) == eff_len) ? ST_EMIT : ST_IDLE;
         end
      end

      case (state_ff)
         ST_IDLE: begin
         end
         ST_MOVE: begin
            if (back_count_ff != '0) begin
               back_re       = 1'b1;
               back_count_in = back_dec;
               mv_pend_in    = 1'b1;
            end
            if (mv_pend_ff) begin
               front_we       = 1'b1;
               fpm_in         = move_pm;
               front_count_in = front_count_ff + CW'(1);
            end
            if ((back_count_ff == '0) && !mv_pend_ff) begin
               brm_in   = KEY_MIN;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_key ^ SIGN_BIT;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // length write empties the window
      if (csr_chan.valid && csr_chan.ready) begin
         len_in         = csr_chan.window_length;
         fill_count_in  = '0;
         back_count_in  = '0;
         front_count_in = '0;
         brm_in         = KEY_MIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         len_ff         <= LEN_W'(1);
         fill_count_ff  <= '0;
         back_count_ff  <= '0;
         front_count_ff <= '0;
         brm_ff         <= KEY_MIN;
         mv_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         len_ff         <= len_in;
         fill_count_ff  <= fill_count_in;
         back_count_ff  <= back_count_in;
         front_count_ff <= front_count_in;
         brm_ff         <= brm_in;
         mv_pend_ff     <= mv_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fpm_ff      <= fpm_in;
      key_ff      <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: src/swm_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for the sliding window maximum top level
`timescale 1ns / 1ps

module testbench;
   import swm_pkg::*;

   localparam int WIN_DEPTH = WINDOW_MAX_DEF;
   localparam int SW        = SAMPLE_WIDTH_DEF;
   localparam int DRAIN     = WIN_DEPTH + 8;
   localparam int LIMIT     = 400000;
   localparam int HOLD_LEN  = 300;
   localparam int EXP_DEPTH = 1024;

   typedef logic signed [SW-1:0] sample_type;
   localparam sample_type MOST_NEG = {1'b1, {(SW-1){1'b0}}};
   localparam sample_type MOST_POS = ~MOST_NEG;

   typedef enum logic {ROW_WORD, ROW_CFG} row_kind_type;
   typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      row_kind_type kind;
      logic [31:0]  value;
      logic         typed;
      logic [31:0]  want;
   } dir_row_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [15:0]      count;
      idle_mode_type    mode;
      logic             pressure;
   } phase_type;

   localparam int DIR_ROWS = 25;
   localparam int PHASES   = 8;

   dir_row_type dir_tab [0:DIR_ROWS-1] = '{
      '{ROW_WORD, 32'h8000_0000, 1'b1, 32'h8000_0000},
      '{ROW_WORD, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{ROW_WORD, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{ROW_WORD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{ROW_CFG,  32'd0,         1'b0, 32'h0},
      '{ROW_WORD, 32'd5,         1'b1, 32'd5},
      '{ROW_WORD, 32'hFFFF_FFF9, 1'b1, 32'hFFFF_FFF9},
      '{ROW_CFG,  32'd4,         1'b0, 32'h0},
      '{ROW_WORD, 32'd1,         1'b0, 32'h0},
      '{ROW_WORD, 32'd2,         1'b0, 32'h0},
      '{ROW_CFG,  32'd2,         1'b0, 32'h0},
      '{ROW_WORD, 32'd3,         1'b0, 32'h0},
      '{ROW_WORD, 32'd4,         1'b0, 32'h0},
      '{ROW_CFG,  32'd3,         1'b0, 32'h0},
      '{ROW_WORD, 32'hFFFF_FFFB, 1'b0, 32'h0},
      '{ROW_WORD, 32'hFFFF_FFF7, 1'b0, 32'h0},
      '{ROW_WORD, 32'hFFFF_FFFD, 1'b0, 32'h0},
      '{ROW_WORD, 32'd7,         1'b0, 32'h0},
      '{ROW_WORD, 32'hFFFF_FF9C, 1'b0, 32'h0},
      '{ROW_WORD, 32'hFFFF_FF9C, 1'b0, 32'h0},
      '{ROW_WORD, 32'hFFFF_FF9C, 1'b0, 32'h0},
      '{ROW_CFG,  32'd2,         1'b0, 32'h0},
      '{ROW_WORD, 32'h8000_0000, 1'b0, 32'h0},
      '{ROW_WORD, 32'h8000_0000, 1'b1, 32'h8000_0000},
      '{ROW_WORD, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF}
   };

   phase_type phase_tab [0:PHASES-1] = '{
      '{9'd1,   16'd30,  IDLE_NONE, 1'b0},
      '{9'd2,   16'd40,  IDLE_SEND, 1'b0},
      '{9'd5,   16'd50,  IDLE_RECV, 1'b0},
      '{9'd0,   16'd20,  IDLE_BOTH, 1'b0},
      '{9'd17,  16'd60,  IDLE_BOTH, 1'b1},
      '{9'd256, 16'd150, IDLE_NONE, 1'b0},
      '{9'd511, 16'd262, IDLE_BOTH, 1'b0},
      '{9'd3,   16'd40,  IDLE_RECV, 1'b0}
   };

   logic clock;
   logic reset;

   swm_req_if req_ch ();
   swm_rsp_if rsp_ch ();
   swm_csr_if csr_ch ();

   sliding_window_max_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_ch),
      .rsp_chan (rsp_ch),
      .csr_chan (csr_ch)
   );

   // window state of the predictor
   logic [LEN_W-1:0] cur_len;
   sample_type       back_stack [WIN_DEPTH];
   sample_type       back_peak;
   int               back_depth;
   sample_type       front_peak [WIN_DEPTH];
   int               front_depth;
   int               taken;

   // expected words in order, written by the sender and read by the monitor
   sample_type exp_store [EXP_DEPTH];
   int         exp_wr;
   int         exp_rd;
   sample_type oldest_max;
   int         send_pct;
   int         recv_pct;
   int         hold_req;
   int         hold_left;
   int         mismatches;
   int         words_sent;
   int         results_seen;
   int         cfg_writes;
   int         cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic sample_type larger(input sample_type a, input sample_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic int active_len();
      if (cur_len == 0) return 1;
      if (cur_len > WIN_DEPTH) return WIN_DEPTH;
      return int'(cur_len);
   endfunction

   function automatic void empty_window();
      back_peak   = MOST_NEG;
      back_depth  = 0;
      front_depth = 0;
      taken       = 0;
   endfunction

   function automatic int pending();
      return exp_wr - exp_rd;
   endfunction

   function automatic void put_expected(input sample_type v);
      exp_store[exp_wr & (EXP_DEPTH - 1)] = v;
      exp_wr++;
   endfunction

   function automatic sample_type take_expected();
      sample_type v;
      v = exp_store[exp_rd & (EXP_DEPTH - 1)];
      exp_rd++;
      return v;
   endfunction

   function automatic bit window_step(input sample_type s, output sample_type m);
      int         len;
      sample_type below;
      len = active_len();
      m   = MOST_NEG;
      if (taken < len) begin
         taken++;
      end else begin
         // front stack empty: move the back stack across
         if (front_depth == 0) begin
            while (back_depth > 0) begin
               back_depth--;
               below = (front_depth > 0) ? front_peak[front_depth-1] : MOST_NEG;
               front_peak[front_depth] = larger(below, back_stack[back_depth]);
               front_depth++;
            end
            back_peak = MOST_NEG;
         end
         if (front_depth > 0) front_depth--;
      end
      if (back_depth < WIN_DEPTH) begin
         back_stack[back_depth] = s;
         back_depth++;
         back_peak = larger(back_peak, s);
      end
      if (taken < len) return 1'b0;
      m = (front_depth == 0) ? back_peak : larger(back_peak, front_peak[front_depth-1]);
      return 1'b1;
   endfunction

   function automatic sample_type rand_sample();
      sample_type v;
      case ($urandom_range(9))
         0: v = MOST_NEG;
         1: v = MOST_POS;
         2: v = MOST_NEG + sample_type'($urandom_range(15));
         3: v = MOST_POS - sample_type'($urandom_range(15));
         4, 5: v = sample_type'($urandom_range(40)) - 20;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic flag_mismatch(input string what, input sample_type want,
                                input sample_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %0d (%s): expected %0d, got %0d", mismatches, what, want, got);
   endtask

   task automatic wait_empty();
      while (pending() != 0) @(posedge clock);
   endtask

   task automatic idle_gap();
      while ($urandom_range(99) < send_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_word(input sample_type s, input bit typed, input sample_type want);
      sample_type m;
      @(negedge clock);
      req_ch.valid  <= 1'b1;
      req_ch.sample <= s;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
      if (window_step(s, m) || typed)
         put_expected(typed ? want : m);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] v);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait_empty();
      // let the block settle before the write
      repeat (DRAIN) @(posedge clock);
      @(negedge clock);
      csr_ch.valid         <= 1'b1;
      csr_ch.window_length <= v;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      cur_len = v;
      empty_window();
      cfg_writes++;
   endtask

   // result side ready, with long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      hold_left    = 0;
      forever begin
         @(negedge clock);
         if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending() == 0) begin
            flag_mismatch("unexpected word", MOST_NEG, rsp_ch.window_max);
         end else begin
            oldest_max = take_expected();
            results_seen++;
            if (rsp_ch.window_max !== oldest_max)
               flag_mismatch("window_max", oldest_max, rsp_ch.window_max);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycles, pending());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int r;
      int p;
      int n;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.sample        = '0;
      csr_ch.valid         = 1'b0;
      csr_ch.window_length = '0;
      send_pct             = 0;
      recv_pct             = 0;
      hold_req             = 0;
      mismatches           = 0;
      words_sent           = 0;
      results_seen         = 0;
      cfg_writes           = 0;
      cycles               = 0;
      exp_wr               = 0;
      exp_rd               = 0;
      cur_len              = 1;
      empty_window();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < DIR_ROWS; r++) begin
         if (dir_tab[r].kind == ROW_CFG)
            write_length(dir_tab[r].value[LEN_W-1:0]);
         else
            send_word(dir_tab[r].value, dir_tab[r].typed, dir_tab[r].want);
      end

      for (p = 0; p < PHASES; p++) begin
         send_pct = (phase_tab[p].mode == IDLE_SEND) ? 82 :
                    (phase_tab[p].mode == IDLE_BOTH) ? 30 : 0;
         recv_pct = (phase_tab[p].mode == IDLE_RECV) ? 82 :
                    (phase_tab[p].mode == IDLE_BOTH) ? 30 : 0;
         write_length(phase_tab[p].len);
         for (n = 0; n < phase_tab[p].count; n++) begin
            if (phase_tab[p].pressure && n == phase_tab[p].count / 3)
               hold_req = HOLD_LEN;
            if (phase_tab[p].pressure && n == 2 * phase_tab[p].count / 3) begin
               @(negedge clock);
               req_ch.valid <= 1'b0;
               wait_empty();
            end
            idle_gap();
            send_word(rand_sample(), 1'b0, MOST_NEG);
         end
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait_empty();
      repeat (DRAIN) @(posedge clock);
      if (pending() != 0) begin
         mismatches += pending();
         $display("%0d window maximum words never arrived", pending());
      end

      $display("%0d samples sent, %0d window maxima checked, %0d length writes",
               words_sent, results_seen, cfg_writes);
      $display("lengths 0 to 511 under four idling patterns and a long result hold-off");
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: filelist.f
src/swm_pkg.sv
src/swm_if.sv
src/swm_ram.sv
src/sliding_window_max_top.sv
tb/sv/testbench.sv
